// ----- rtl/core/ubr_pkg.sv -----
`default_nettype none

package ubr_pkg;

  // Transaction kinds
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LINE  = 2'd2;

  // Register byte offsets
  localparam logic [7:0] ADDR_RBR  = 8'h00;
  localparam logic [7:0] ADDR_IER  = 8'h01;
  localparam logic [7:0] ADDR_IIR  = 8'h02;
  localparam logic [7:0] ADDR_LCR  = 8'h03;
  localparam logic [7:0] ADDR_MCR  = 8'h04;
  localparam logic [7:0] ADDR_LSR  = 8'h05;
  localparam logic [7:0] ADDR_MSR  = 8'h06;
  localparam logic [7:0] ADDR_SPR  = 8'h07;
  localparam logic [7:0] ADDR_MDR1 = 8'h08;
  localparam logic [7:0] ADDR_SCR  = 8'h10;
  localparam logic [7:0] ADDR_SSR  = 8'h11;

  // LCR value that selects the enhanced register bank
  localparam logic [7:0] LCR_BANK_CONF = 8'hBF;
  // Modem status outside the enhanced bank: CTS, DSR, DCD
  localparam logic [7:0] MSR_IDLE = 8'hB0;

  // Interrupt identification codes
  localparam logic [3:0] ID_NONE = 4'h1;
  localparam logic [3:0] ID_LINE = 4'h6;
  localparam logic [3:0] ID_DATA = 4'h4;
  localparam logic [3:0] ID_TXE  = 4'h2;

  // IER and FCR bit positions
  localparam int unsigned IER_RDA    = 0;
  localparam int unsigned IER_THRE   = 1;
  localparam int unsigned IER_RLS    = 2;
  localparam int unsigned FCR_RX_RST = 1;
  localparam int unsigned FCR_TX_RST = 2;

  // RX FIFO control and status
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } rxf_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic single;
  } rxf_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ubr_if.sv -----
`default_nettype none

// Request channel: bus read, bus write or line byte
interface ubr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] addr;
  logic [7:0] wdata;
  logic [7:0] rx_byte;

  modport source (output valid, op, addr, wdata, rx_byte, input ready);
  modport sink   (input valid, op, addr, wdata, rx_byte, output ready);
endinterface

// Result channel: one result per request
interface ubr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       irq_line;
  logic       tx_valid;
  logic [7:0] tx_byte;

  modport source (output valid, rdata, irq_line, tx_valid, tx_byte, input ready);
  modport sink   (input valid, rdata, irq_line, tx_valid, tx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/uart_banked_registers_rx_fifo.sv -----
`default_nettype none
// A transaction is held in the request register, and its result is registered in the result register.
// Throughput: one transaction per cycle; the request and result registers each take a new
// transaction every cycle while the result side keeps taking results.
// Reset (rst_ni low, asynchronous): registers to 16550 defaults, LSR 0x60, IIR 0x01, RX FIFO
// empty; FIFO storage is not cleared and needs no clearing pass.

module uart_banked_registers_rx_fifo
  import ubr_pkg::*;
#(
  parameter int unsigned RX_DEPTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ubr_in_if.sink    in_i,
  ubr_out_if.source out_o
);

  // Request register
  logic       in_valid_q;
  logic [1:0] op_q;
  logic [7:0] addr_q, wdata_q, rxb_q;

  // Result register
  logic       out_valid_q;
  logic [7:0] rdata_q, rdata_d, tx_byte_q, tx_byte_d;
  logic       irq_q, irq_d, tx_valid_q, tx_valid_d;

  // Architectural registers
  logic [3:0] ier_q, ier_d, ident_q, ident_d;
  logic [7:0] lcr_q, lcr_d, mcr_q, mcr_d, spr_q, spr_d;
  logic [7:0] dll_q, dll_d, dlm_q, dlm_d, mdr1_q, mdr1_d, efr_q, efr_d;
  logic [7:0] xon1_q, xon1_d, xon2_q, xon2_d, xoff1_q, xoff1_d, xoff2_q, xoff2_d;
  logic [7:0] scr_q, scr_d;
  logic [6:0] ssr_q, ssr_d;
  logic       data_q, data_d, over_q, over_d, pend_q, pend_d;
  logic [1:0] iir_cnt_q, iir_cnt_d;

  logic       advance, conf, dlab, reeval;
  rxf_ctrl_t  rxf_ctrl;
  rxf_stat_t  rxf_stat;
  logic [7:0] rxf_rdata;

  // Pipeline handshake
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign conf        = (lcr_q == LCR_BANK_CONF);
  assign dlab        = lcr_q[7];

  ubr_rx_fifo #(
    .RX_DEPTH(RX_DEPTH)
  ) u_rx_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rxf_ctrl),
    .wdata_i(rxb_q),
    .stat_o (rxf_stat),
    .rdata_o(rxf_rdata)
  );

  // Register access and interrupt update for the transaction in the request register
  always_comb begin
    ier_d = ier_q;  ident_d = ident_q;  lcr_d = lcr_q;  mcr_d = mcr_q;
    spr_d = spr_q;  dll_d = dll_q;  dlm_d = dlm_q;  mdr1_d = mdr1_q;
    efr_d = efr_q;  xon1_d = xon1_q;  xon2_d = xon2_q;  xoff1_d = xoff1_q;
    xoff2_d = xoff2_q;  scr_d = scr_q;  ssr_d = ssr_q;
    data_d = data_q;  over_d = over_q;  pend_d = pend_q;  iir_cnt_d = iir_cnt_q;
    rdata_d    = '0;
    tx_valid_d = 1'b0;
    tx_byte_d  = '0;
    reeval     = 1'b0;
    rxf_ctrl   = '0;
    if (advance) begin
      case (op_q)
        OP_READ: begin
          unique case (addr_q)
            ADDR_RBR: begin
              if (dlab) begin
                rdata_d = dll_q;
              end else begin
                rxf_ctrl.pop = 1'b1;
                if (!rxf_stat.empty) rdata_d = rxf_rdata;
                data_d = !(rxf_stat.empty || rxf_stat.single);
                reeval = 1'b1;
              end
            end
            ADDR_IER: rdata_d = dlab ? dlm_q : {4'b0, ier_q};
            ADDR_IIR: begin
              if (conf) begin
                rdata_d = efr_q;
              end else begin
                rdata_d = {4'b0, ident_q};
                // TX empty clears on the second IIR read
                if (ident_q == ID_TXE) begin
                  if (iir_cnt_q == 2'd1) begin
                    pend_d    = 1'b0;
                    iir_cnt_d = '0;
                    reeval    = 1'b1;
                  end else begin
                    iir_cnt_d = iir_cnt_q + 2'd1;
                  end
                end
              end
            end
            ADDR_LCR: rdata_d = lcr_q;
            ADDR_MCR: rdata_d = conf ? xon1_q : mcr_q;
            ADDR_LSR: begin
              if (conf) begin
                rdata_d = xon2_q;
              end else begin
                rdata_d = {3'b011, 3'b000, over_q, data_q};
                over_d  = 1'b0;
              end
            end
            ADDR_MSR:  rdata_d = conf ? xoff1_q : MSR_IDLE;
            ADDR_SPR:  rdata_d = conf ? xoff2_q : spr_q;
            ADDR_MDR1: rdata_d = mdr1_q;
            ADDR_SCR:  rdata_d = scr_q;
            ADDR_SSR:  rdata_d = {ssr_q, 1'b0};
            default:   rdata_d = '0;
          endcase
        end
        OP_WRITE: begin
          unique case (addr_q)
            ADDR_RBR: begin
              if (dlab) begin
                dll_d = wdata_q;
              end else begin
                tx_valid_d = 1'b1;
                tx_byte_d  = wdata_q;
                pend_d     = 1'b1;
                iir_cnt_d  = '0;
                reeval     = 1'b1;
              end
            end
            ADDR_IER: begin
              if (dlab) begin
                dlm_d = wdata_q;
              end else begin
                ier_d = wdata_q[3:0];
                // THRE enable edge with THR empty (always true here)
                if (!ier_q[IER_THRE] && wdata_q[IER_THRE]) pend_d = 1'b1;
                reeval = 1'b1;
              end
            end
            ADDR_IIR: begin
              if (conf) begin
                efr_d = wdata_q;
              end else begin
                if (wdata_q[FCR_RX_RST]) begin
                  rxf_ctrl.clear = 1'b1;
                  data_d         = 1'b0;
                end
                if (wdata_q[FCR_TX_RST]) pend_d = 1'b0;
                reeval = 1'b1;
              end
            end
            ADDR_LCR: lcr_d = wdata_q;
            ADDR_MCR: begin
              if (conf) xon1_d = wdata_q;
              else      mcr_d  = wdata_q;
            end
            ADDR_LSR: if (conf) xon2_d = wdata_q;
            ADDR_MSR: if (conf) xoff1_d = wdata_q;
            ADDR_SPR: begin
              if (conf) xoff2_d = wdata_q;
              else      spr_d   = wdata_q;
            end
            ADDR_MDR1: mdr1_d = wdata_q;
            ADDR_SCR:  scr_d  = wdata_q;
            ADDR_SSR:  ssr_d  = wdata_q[7:1];
            default: ;
          endcase
        end
        OP_LINE: begin
          rxf_ctrl.push = 1'b1;
          if (rxf_stat.full) over_d = 1'b1;
          data_d = 1'b1;
          reeval = 1'b1;
        end
        default: ;
      endcase
      // Priority: overrun, data ready, TX empty
      if (reeval) begin
        if (ier_d[IER_RLS] && over_d)       ident_d = ID_LINE;
        else if (ier_d[IER_RDA] && data_d)  ident_d = ID_DATA;
        else if (ier_d[IER_THRE] && pend_d) ident_d = ID_TXE;
        else                                ident_d = ID_NONE;
      end
    end
  end

  assign irq_d = (ident_d != ID_NONE);

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ier_q   <= '0;  ident_q <= ID_NONE;  lcr_q <= '0;  mcr_q <= '0;
      spr_q   <= '0;  dll_q   <= '0;  dlm_q <= '0;  mdr1_q <= '0;  efr_q <= '0;
      xon1_q  <= '0;  xon2_q  <= '0;  xoff1_q <= '0;  xoff2_q <= '0;
      scr_q   <= '0;  ssr_q   <= '0;
      data_q  <= 1'b0;  over_q <= 1'b0;  pend_q <= 1'b0;  iir_cnt_q <= '0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance)           out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
      ier_q   <= ier_d;  ident_q <= ident_d;  lcr_q <= lcr_d;  mcr_q <= mcr_d;
      spr_q   <= spr_d;  dll_q   <= dll_d;  dlm_q <= dlm_d;  mdr1_q <= mdr1_d;
      efr_q   <= efr_d;
      xon1_q  <= xon1_d;  xon2_q <= xon2_d;  xoff1_q <= xoff1_d;  xoff2_q <= xoff2_d;
      scr_q   <= scr_d;  ssr_q <= ssr_d;
      data_q  <= data_d;  over_q <= over_d;  pend_q <= pend_d;  iir_cnt_q <= iir_cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q   <= in_i.op;
      addr_q <= in_i.addr;
      wdata_q <= in_i.wdata;
      rxb_q  <= in_i.rx_byte;
    end
    if (advance) begin
      rdata_q    <= rdata_d;
      irq_q      <= irq_d;
      tx_valid_q <= tx_valid_d;
      tx_byte_q  <= tx_byte_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.rdata    = rdata_q;
  assign out_o.irq_line = irq_q;
  assign out_o.tx_valid = tx_valid_q;
  assign out_o.tx_byte  = tx_byte_q;

`ifndef SYNTH
  // IIR read counter resets on the second read, never reaches two
  assert property (@(posedge clk_i) disable iff (!rst_ni) iir_cnt_q <= 2'd1)
    else $error("iir read counter out of range");

  // Interrupt level in the result matches the identification it was built from
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (irq_q == (ident_q != ID_NONE)))
    else $error("irq level does not match IIR");

  // A transmitted byte comes only from a write, which returns no read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && tx_valid_d |=> out_valid_q && (rdata_q == 8'h00))
    else $error("tx byte with read data");

  // FIFO level cannot be both empty and full
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(rxf_stat.empty && rxf_stat.full))
    else $error("rx fifo empty and full");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/ubr_rx_fifo.sv -----
`default_nettype none

module ubr_rx_fifo
  import ubr_pkg::*;
#(
  parameter int unsigned RX_DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire rxf_ctrl_t  ctrl_i,
  input  wire logic [7:0] wdata_i,
  output rxf_stat_t       stat_o,
  output logic [7:0]      rdata_o
);

  localparam int unsigned PtrW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned LvlW = $clog2(RX_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(RX_DEPTH - 1);
  localparam logic [LvlW-1:0] LvlFull = LvlW'(RX_DEPTH);

  logic [7:0]      mem [RX_DEPTH];
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [LvlW-1:0] level_q, level_d;
  logic            push_ok, pop_ok;
  logic [7:0]      rd_q, byp_data_q;
  logic            byp_q;

  assign stat_o.empty  = (level_q == '0);
  assign stat_o.full   = (level_q == LvlFull);
  assign stat_o.single = (level_q == LvlW'(1));

  assign push_ok = ctrl_i.push && !stat_o.full;
  assign pop_ok  = ctrl_i.pop && !stat_o.empty;

  // Pointer and level update, wrap at the configured depth
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    level_d = level_q;
    if (ctrl_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      level_d = '0;
    end else begin
      if (push_ok) head_d = (head_q == PtrLast) ? '0 : head_q + PtrW'(1);
      if (pop_ok)  tail_d = (tail_q == PtrLast) ? '0 : tail_q + PtrW'(1);
      level_d = level_q + LvlW'(push_ok) - LvlW'(pop_ok);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      level_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      level_q <= level_d;
      // a write to the slot read next bypasses the memory
      byp_q   <= push_ok && (head_q == tail_d);
    end
  end

  // Storage; the head of the queue is read ahead into a register
  always_ff @(posedge clk_i) begin
    if (push_ok) mem[head_q] <= wdata_i;
    rd_q       <= mem[tail_d];
    byp_data_q <= wdata_i;
  end

  assign rdata_o = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire
